[rtl/sorted_table_key_lookup_core_assert.svh]
// Assertion macros shared by the sorted table lookup modules.
`ifndef SORTED_TABLE_KEY_LOOKUP_CORE_ASSERT_SVH
`define SORTED_TABLE_KEY_LOOKUP_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SKL_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sorted table lookup: assertion failed");
`define SKL_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("sorted table lookup: assertion failed");
`else
`define SKL_ASSERT(label, clk, rst, prop)
`define SKL_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[rtl/skl_pkg.sv]
// Types and constants for the sorted table lookup block.
`default_nettype none

package skl_pkg;

   localparam int KEY_W      = 72;
   localparam int DIST_W     = 32;
   localparam int REC_W      = KEY_W + DIST_W;
   localparam int POS_W      = 7;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 40;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [STATUS_W-1:0] ST_STORED   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic                capture;
      logic                rd_mid;
      logic                shift;
      logic                place;
      logic                srch_step;
      logic                finish;
      logic [STATUS_W-1:0] res_code;
      logic                post;
   } skl_cmd_type;

   typedef struct packed {
      logic is_query;
      logic full;
      logic j_zero;
      logic key_gt;
      logic key_eq;
      logic srch_done;
      logic rsp_free;
   } skl_sts_type;

endpackage

`default_nettype wire

[rtl/skl_ram.sv]
// Generic single write, single read port RAM with registered read data.
`default_nettype none

module skl_ram #(
   parameter int WIDTH = 104,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[rtl/skl_ctrl.sv]
// Sequencer for the sorted table lookup: load insertion and binary search.
`default_nettype none
`include "sorted_table_key_lookup_core_assert.svh"

module skl_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output skl_pkg::skl_cmd_type      cmd,
   input  wire skl_pkg::skl_sts_type sts
);

   import skl_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_LCHK  = 3'd2;
   localparam logic [2:0] S_LCMP  = 3'd3;
   localparam logic [2:0] S_QCHK  = 3'd4;
   localparam logic [2:0] S_QCMP  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_START;
            end
         end
         S_START: begin
            state_in = sts.is_query ? S_QCHK : S_LCHK;
         end
         S_LCHK: begin
            if (sts.full) begin
               cmd.finish   = 1'b1;
               cmd.res_code = ST_FULL;
               state_in     = S_DONE;
            end else if (sts.j_zero) begin
               cmd.place    = 1'b1;
               cmd.finish   = 1'b1;
               cmd.res_code = ST_STORED;
               state_in     = S_DONE;
            end else begin
               // record below the slot is being read
               state_in = S_LCMP;
            end
         end
         S_LCMP: begin
            if (sts.key_gt) begin
               cmd.shift = 1'b1;
               state_in  = S_LCHK;
            end else begin
               cmd.place    = 1'b1;
               cmd.finish   = 1'b1;
               cmd.res_code = ST_STORED;
               state_in     = S_DONE;
            end
         end
         S_QCHK: begin
            if (sts.srch_done) begin
               cmd.finish   = 1'b1;
               cmd.res_code = ST_NOTFOUND;
               state_in     = S_DONE;
            end else begin
               cmd.rd_mid = 1'b1;
               state_in   = S_QCMP;
            end
         end
         S_QCMP: begin
            if (sts.key_eq) begin
               cmd.finish   = 1'b1;
               cmd.res_code = ST_FOUND;
               state_in     = S_DONE;
            end else begin
               cmd.srch_step = 1'b1;
               state_in      = S_QCHK;
            end
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.post = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `SKL_ASSERT(a_capture_starts, clock, reset, cmd.capture |=> (state_ff == S_START))
   `SKL_ASSERT(a_finish_to_done, clock, reset, cmd.finish |=> (state_ff == S_DONE))

endmodule

`default_nettype wire

[rtl/skl_datapath.sv]
// Datapath: record RAM, request latch, insertion and search indices, result registers.
`default_nettype none
`include "sorted_table_key_lookup_core_assert.svh"

module skl_datapath #(
   parameter int DEPTH = 128
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [skl_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic [0:0]                        req_tuser,
   input  wire skl_pkg::skl_cmd_type              cmd,
   output skl_pkg::skl_sts_type                   sts,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [skl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic      [skl_pkg::STATUS_W-1:0]      rsp_tuser
);

   import skl_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic              type_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [CW-1:0]     j_ff;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     lo_ff;
   logic [CW-1:0]     hi_ff;
   logic [AW-1:0]     mid_ff;

   logic [STATUS_W-1:0] res_status_ff;
   logic [POS_W-1:0]    res_pos_ff;
   logic [DIST_W-1:0]   res_dist_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [POS_W-1:0]    rsp_pos_ff;
   logic [DIST_W-1:0]   rsp_dist_ff;

   logic [REC_W-1:0]  rdata;
   logic [REC_W-1:0]  wdata;
   logic [AW-1:0]     raddr;
   logic [AW-1:0]     waddr;
   logic              we;
   logic [KEY_W-1:0]  rd_key;
   logic [DIST_W-1:0] rd_dist;
   logic [CW-1:0]     j_m1;
   logic [CW:0]       mid_sum;
   logic [AW-1:0]     mid_c;

   assign rd_key  = rdata[REC_W-1 -: KEY_W];
   assign rd_dist = rdata[DIST_W-1:0];
   assign j_m1    = j_ff - CW'(1);
   // floor((lo + hi - 1) / 2), only used while lo < hi
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} - {{CW{1'b0}}, 1'b1};
   assign mid_c   = mid_sum[AW:1];

   assign raddr = cmd.rd_mid ? mid_c : j_m1[AW-1:0];
   assign waddr = j_ff[AW-1:0];
   assign we    = cmd.shift | cmd.place;
   assign wdata = cmd.shift ? rdata : {key_ff, dist_ff};

   skl_ram #(
      .WIDTH (REC_W),
      .DEPTH (DEPTH)
   ) u_records (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      sts.is_query  = (type_ff == REQ_QUERY);
      sts.full      = (count_ff == CW'(DEPTH));
      sts.j_zero    = (j_ff == '0);
      sts.key_gt    = (rd_key > key_ff);
      sts.key_eq    = (rd_key == key_ff);
      sts.srch_done = (lo_ff >= hi_ff);
      sts.rsp_free  = !rsp_valid_ff || rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.place) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.post) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= req_tuser[0];
         key_ff  <= {req_tdata[63:0], req_tdata[71:64]};
         dist_ff <= req_tdata[103:72];
         j_ff    <= count_ff;
         lo_ff   <= '0;
         hi_ff   <= count_ff;
      end
      if (cmd.shift) begin
         j_ff <= j_m1;
      end
      if (cmd.rd_mid) begin
         mid_ff <= mid_c;
      end
      if (cmd.srch_step) begin
         if (sts.key_gt) begin
            hi_ff <= CW'(mid_ff);
         end else begin
            lo_ff <= CW'(mid_ff) + CW'(1);
         end
      end
      if (cmd.finish) begin
         res_status_ff <= cmd.res_code;
         if (cmd.res_code == ST_FOUND) begin
            res_pos_ff  <= POS_W'(mid_ff);
            res_dist_ff <= rd_dist;
         end else begin
            res_pos_ff  <= '0;
            res_dist_ff <= '0;
         end
      end
      if (cmd.post) begin
         rsp_status_ff <= res_status_ff;
         rsp_pos_ff    <= res_pos_ff;
         rsp_dist_ff   <= res_dist_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_dist_ff, rsp_pos_ff};
   assign rsp_tuser  = rsp_status_ff;

   `SKL_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(DEPTH))
   `SKL_ASSERT(a_no_write_full, clock, reset, we |-> !sts.full)
   `SKL_ASSERT(a_place_counts, clock, reset, cmd.place |=> (count_ff == $past(count_ff) + CW'(1)))
   `SKL_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_valid_ff && (count_ff == '0)))

endmodule

`default_nettype wire

[rtl/sorted_table_key_lookup_core.sv]
// Top level of the sorted table key lookup block.
`default_nettype none

// Table of up to DEPTH records (72-bit key, 32-bit distance in hundredths) in
// one RAM, kept in stable ascending key order. A load inserts its record at
// its sorted place behind any equal keys, moving greater records up one slot.
// Each move is a read through the RAM read port and a write through its
// write port. A load steps down from the end of the table, reading the record
// below the slot, comparing its key and shifting it up while it is greater,
// then writes the new record. A load into a full table answers table full.
// A query is a binary search, one RAM read and key compare per probe, with
// at most ceil(log2(DEPTH+1)) probes. A finished result waits until the
// output register can take it. One request is worked at a time. A new
// request is taken in the cycle after the previous result enters the output
// register, even if that result has not yet been taken. The RAM needs no
// clearing after reset, so requests are taken straight away.
module sorted_table_key_lookup_core #(
   parameter int DEPTH = 128
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // fields from bit 0: key_head[63:0], key_tail[71:64], distance_in[103:72]
   input  wire logic [skl_pkg::REQ_DATA_W-1:0] req_tdata,
   // fields from bit 0: req_type[0]
   input  wire logic [0:0]                     req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // fields from bit 0: position[6:0], distance_out[38:7], zero pad [39]
   output logic      [skl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // fields from bit 0: status[1:0]
   output logic      [skl_pkg::STATUS_W-1:0]   rsp_tuser
);

   import skl_pkg::*;

   skl_cmd_type cmd;
   skl_sts_type sts;

   skl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   skl_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

[sim/tb_sorted_table_key_lookup_core.sv]
// Testbench for the sorted table key lookup core: loads and key queries checked against a local table.
`timescale 1ns / 100ps

module tb_sorted_table_key_lookup_core;
   import skl_pkg::*;

   localparam int DEPTH = 128;
   // longest load moves every record once, plus margin
   localparam int SETTLE_CYCLES = 2 * DEPTH + 40;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [DIST_W-1:0]   distance;
   } lookup_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   // fields from bit 0: key_head[63:0], key_tail[71:64], distance_in[103:72]
   logic [REQ_DATA_W-1:0] req_tdata;
   // fields from bit 0: req_type[0]
   logic [0:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // fields from bit 0: position[6:0], distance_out[38:7], zero pad [39]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // fields from bit 0: status[1:0]
   logic [STATUS_W-1:0]   rsp_tuser;

   // local copy of the table, always held in stable key order
   logic [KEY_W-1:0]  table_key [DEPTH];
   logic [DIST_W-1:0] table_dist [DEPTH];
   int                record_count = 0;

   lookup_result_type pending_results[$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                stall_left = 0;

   sorted_table_key_lookup_core #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   initial begin
      #3_000_000;
      $display("tb: failure");
      $finish;
   end

   // updates the local table and works out the answer to one request
   function automatic lookup_result_type predict_lookup(input logic kind,
                                                        input logic [KEY_W-1:0] key,
                                                        input logic [DIST_W-1:0] load_dist);
      lookup_result_type res;
      int slot;
      int lo;
      int hi;
      int mid;
      res = '0;
      if (kind == REQ_LOAD) begin
         if (record_count >= DEPTH) begin
            res.status = ST_FULL;
         end else begin
            // goes in behind any equal keys, so load order is kept
            slot = record_count;
            while (slot > 0 && table_key[slot-1] > key) begin
               table_key[slot]  = table_key[slot-1];
               table_dist[slot] = table_dist[slot-1];
               slot--;
            end
            table_key[slot]  = key;
            table_dist[slot] = load_dist;
            record_count++;
            res.status = ST_STORED;
         end
      end else begin
         res.status = ST_NOTFOUND;
         lo = 0;
         hi = record_count;
         while (lo < hi) begin
            mid = (lo + hi - 1) / 2;
            if (table_key[mid] == key) begin
               res.status   = ST_FOUND;
               res.position = mid[POS_W-1:0];
               res.distance = table_dist[mid];
               lo = hi;
            end else if (table_key[mid] < key) begin
               lo = mid + 1;
            end else begin
               hi = mid;
            end
         end
      end
      return res;
   endfunction

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DIST_W-1:0] random_distance();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // few fixed keys so that duplicates and close neighbours turn up often
   function automatic logic [KEY_W-1:0] pool_key();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         2:       return 72'h41_42_43_00_00_00_00_00_00;
         3:       return 72'h41_42_43_00_00_00_00_00_01;
         default: return 72'h80_00_00_00_00_00_00_00_00;
      endcase
   endfunction

   function automatic logic [KEY_W-1:0] random_key();
      logic [KEY_W-1:0] k;
      int               n;
      k[71:40] = $urandom;
      k[39:8]  = $urandom;
      k[7:0]   = $urandom_range(0, 255);
      n = $urandom_range(1, 8);
      case ($urandom_range(0, 3))
         // short name, zero padded
         0: k = k & ~((72'd1 << (8 * n)) - 72'd1);
         // zero byte with live bytes after it
         1: k[8*n +: 8] = 8'h00;
         default: ;
      endcase
      return k;
   endfunction

   function automatic logic [KEY_W-1:0] stored_key();
      if (record_count == 0) return random_key();
      return table_key[$urandom_range(0, record_count - 1)];
   endfunction

   task automatic send_request(input logic kind, input logic [KEY_W-1:0] key,
                               input logic [DIST_W-1:0] load_dist, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {load_dist, key[7:0], key[71:8]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(predict_lookup(kind, key, load_dist));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input lookup_result_type want,
                                  input lookup_result_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: expected status %0d pos %0d dist %h, got status %0d pos %0d dist %h",
                  $realtime, what, want.status, want.position, want.distance,
                  got.status, got.position, got.distance);
   endtask

   always @(posedge clock) begin : result_check
      lookup_result_type want;
      lookup_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status   = rsp_tuser;
         got.position = rsp_tdata[6:0];
         got.distance = rsp_tdata[38:7];
         if (pending_results.size() == 0) begin
            report_mismatch("response with no request outstanding", '0, got);
         end else begin
            want = pending_results.pop_front();
            if (got.status != want.status || got.position != want.position ||
                got.distance != want.distance)
               report_mismatch("response mismatch", want, got);
         end
      end
   end

   // back-pressure: short and long stalls, with a quiet stretch whenever cycle_count[9:8] is 3
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (cycle_count[9:8] != 2'b11 && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic test_empty_table();
      send_request(REQ_QUERY, '0, random_distance(), random_gap());
      send_request(REQ_QUERY, '1, '1, random_gap());
   endtask

   task automatic test_key_extremes();
      send_request(REQ_LOAD, '0, '0, random_gap());
      send_request(REQ_LOAD, '1, '1, random_gap());
      send_request(REQ_LOAD, 72'h00_00_00_00_00_00_00_00_01, 32'h0000_2710, random_gap());
      send_request(REQ_QUERY, '0, '1, random_gap());
      send_request(REQ_QUERY, '1, '0, random_gap());
      send_request(REQ_QUERY, 72'hFF_FF_FF_FF_FF_FF_FF_FF_FE, random_distance(), random_gap());
      send_request(REQ_QUERY, 72'h00_00_00_00_00_00_00_00_01, random_distance(), random_gap());
   endtask

   task automatic test_zero_byte_keys();
      send_request(REQ_LOAD, 72'h41_00_00_00_00_00_00_00_00, 32'd150, random_gap());
      send_request(REQ_LOAD, 72'h41_00_42_00_00_00_00_00_00, 32'd275, random_gap());
      send_request(REQ_LOAD, 72'h41_00_00_00_00_00_00_00_01, 32'd999, random_gap());
      send_request(REQ_QUERY, 72'h41_00_00_00_00_00_00_00_00, random_distance(), random_gap());
      send_request(REQ_QUERY, 72'h41_00_42_00_00_00_00_00_00, random_distance(), random_gap());
      send_request(REQ_QUERY, 72'h41_00_00_00_00_00_00_00_01, random_distance(), random_gap());
      send_request(REQ_QUERY, 72'h41_00_42_00_00_00_00_00_02, random_distance(), random_gap());
   endtask

   task automatic test_equal_keys();
      logic [KEY_W-1:0] k;
      k = 72'h46_49_41_54_00_00_00_00_00;
      send_request(REQ_LOAD, k, 32'd1, random_gap());
      send_request(REQ_LOAD, k, 32'd2, random_gap());
      send_request(REQ_LOAD, k, 32'd3, random_gap());
      send_request(REQ_QUERY, k, random_distance(), random_gap());
   endtask

   task automatic test_random_traffic(input int count);
      logic [KEY_W-1:0] k;
      int               gap;
      int               load_odds;
      for (int i = 0; i < count; i++) begin
         gap = ((i / 50) % 4 == 3) ? 0 : random_gap();
         load_odds = (record_count < DEPTH) ? 5 : 10;
         if ($urandom_range(1, load_odds) == 1) begin
            case ($urandom_range(0, 9))
               0, 1, 2: k = pool_key();
               3, 4:    k = stored_key();
               default: k = random_key();
            endcase
            send_request(REQ_LOAD, k, random_distance(), gap);
         end else begin
            case ($urandom_range(0, 19))
               0, 1, 2:    k = stored_key() ^ (72'd1 << $urandom_range(0, KEY_W - 1));
               3, 4:       k = pool_key();
               5, 6, 7:    k = random_key();
               default:    k = stored_key();
            endcase
            send_request(REQ_QUERY, k, random_distance(), gap);
         end
         // let every outstanding request finish now and then
         if (i % 250 == 249) drain_results();
      end
   endtask

   task automatic test_full_table();
      while (record_count < DEPTH)
         send_request(REQ_LOAD, random_key(), random_distance(), random_gap());
      for (int i = 0; i < 6; i++)
         send_request(REQ_LOAD, ($urandom_range(0, 1) == 1) ? stored_key() : random_key(),
                      random_distance(), random_gap());
      for (int i = 0; i < 10; i++)
         send_request(REQ_QUERY, stored_key(), random_distance(), random_gap());
      send_request(REQ_QUERY, random_key(), random_distance(), random_gap());
   endtask

   initial begin
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= REQ_LOAD;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_key_extremes();
      test_zero_byte_keys();
      test_equal_keys();
      drain_results();
      test_random_traffic(810);
      test_full_table();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
